// ===== sv/lcsd_pkg.sv =====
// Package for the LED channel scale and dither block.
// Holds store sizing, field widths and configuration register codes.
// Has no dependencies.
`default_nettype none

package lcsd_pkg;

  localparam int NumLeds   = 256;
  localparam int SlotCount = NumLeds * 3;
  localparam int SlotAddrW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  localparam int ValueW = 8;
  localparam int SlotW  = 10;
  localparam int GainW  = 17;
  localparam int ExactW = 16;
  localparam int ResW   = 8;
  localparam int CfgIdxW = 1;

  localparam logic [GainW-1:0] GainUnity  = 17'h10000;
  localparam logic [ResW-1:0]  DecorStep  = 8'd149;
  localparam logic [ValueW-1:0] LevelMax  = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGain   = 1'b0,
    CfgDither = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== sv/led_channel_scale_dither.sv =====
// Top level of the LED channel scale and dither block.
// Three-stage pipeline with a residual store per slot; depends on lcsd_pkg.
// Contains the store, its clearing sequencer and the forwarding logic.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   channel_value_i, slot_index_i
//   out      output     out_valid_o / out_ready_i level_out_o
//   cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// Items pass stage one, stage two and output, one per cycle unless stalled.
// The store read issued at acceptance and the write in stage two set the latency.
// After reset the store is swept once over its 768 slots, one entry per cycle,
// and no item is accepted until that pass is done.
// A stall at the output holds all stages together; nothing is lost or repeated.
`default_nettype none

module led_channel_scale_dither
  import lcsd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [GainW-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ValueW-1:0]    channel_value_i,
  input  wire logic [SlotW-1:0]     slot_index_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [ValueW-1:0]         level_out_o
);

  logic [GainW-1:0]     gain_q;
  logic                 dith_q;

  logic                 clr_busy_q, clr_busy_d;
  logic [SlotAddrW-1:0] clr_addr_q, clr_addr_d;
  logic [ResW-1:0]      clr_pat_q, clr_pat_d;

  logic [ResW-1:0]      mem [SlotCount];
  logic                 mem_we;
  logic [SlotAddrW-1:0] mem_waddr;
  logic [ResW-1:0]      mem_wdata;
  logic [ResW-1:0]      rd_q;

  logic                 adv;
  logic                 accept;

  logic                 s1_valid_q;
  logic                 s1_dith_q;
  logic [ValueW-1:0]    s1_val_q;
  logic [SlotAddrW-1:0] s1_slot_q;
  logic [ResW-1:0]      s1_res;
  logic [GainW+ValueW-1:0] s1_prod;

  logic                 s2_valid_q;
  logic                 s2_dith_q;
  logic [SlotAddrW-1:0] s2_slot_q;
  logic [ExactW-1:0]    s2_exact_q;
  logic [ResW-1:0]      s2_res_q, s2_res_d;
  logic [ExactW:0]      s2_sum;
  logic [ValueW-1:0]    s2_level;
  logic                 s2_write;

  logic                 wr_valid_q;
  logic [SlotAddrW-1:0] wr_slot_q;
  logic [ResW-1:0]      wr_data_q;

  logic                 out_valid_q;
  logic [ValueW-1:0]    out_level_q;

  logic                 in_dith;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainUnity;
      dith_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgGain: begin
          gain_q <= (cfg_wdata_i > GainUnity) ? GainUnity : cfg_wdata_i;
        end
        CfgDither: begin
          dith_q <= cfg_wdata_i[0];
        end
        default: begin
          gain_q <= gain_q;
        end
      endcase
    end
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    clr_pat_d  = clr_pat_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      clr_pat_d  = clr_pat_q + DecorStep;
      if (clr_addr_q == SlotAddrW'(SlotCount - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      clr_pat_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
      clr_pat_q  <= clr_pat_d;
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !clr_busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign in_dith    = dith_q && (32'(slot_index_i) < SlotCount);

  // Stage one: the store read lands in rd_q; a write made at the same edge
  // is picked up from the last-write register.
  assign s1_res  = (wr_valid_q && (wr_slot_q == s1_slot_q)) ? wr_data_q : rd_q;
  assign s1_prod = s1_val_q * gain_q;

  // Stage two: the item ahead of this one writes at the edge that moves it on.
  assign s2_res_d = (s2_write && (s2_slot_q == s1_slot_q)) ? s2_sum[ResW-1:0] : s1_res;

  assign s2_sum   = {1'b0, s2_exact_q} + {{(ExactW + 1 - ResW){1'b0}}, s2_res_q};
  assign s2_write = s2_valid_q && s2_dith_q;

  always_comb begin
    if (s2_dith_q) begin
      s2_level = (s2_sum[ExactW:ResW] > {1'b0, LevelMax}) ? LevelMax : s2_sum[ExactW-1:ResW];
    end else begin
      s2_level = s2_exact_q[ExactW-1:ResW];
    end
  end

  assign mem_we    = clr_busy_q || (adv && s2_write);
  assign mem_waddr = clr_busy_q ? clr_addr_q : s2_slot_q;
  assign mem_wdata = clr_busy_q ? clr_pat_q : s2_sum[ResW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rd_q <= mem[SlotAddrW'(slot_index_i)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wr_valid_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      wr_valid_q  <= s2_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_val_q    <= channel_value_i;
      s1_slot_q   <= SlotAddrW'(slot_index_i);
      s1_dith_q   <= in_dith;
      s2_exact_q  <= s1_prod[ExactW+ResW-1:ResW];
      s2_res_q    <= s2_res_d;
      s2_slot_q   <= s1_slot_q;
      s2_dith_q   <= s1_dith_q;
      out_level_q <= s2_level;
      wr_slot_q   <= s2_slot_q;
      wr_data_q   <= s2_sum[ResW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_out_o = out_level_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("Item accepted during the store clearing pass.");

  a_empty_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(s1_valid_q || s2_valid_q || wr_valid_q))
    else $error("Pipeline holds an item during the store clearing pass.");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("Accepted item did not enter stage one.");

  a_stall_holds_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(s2_valid_q) && $stable(s1_valid_q) && !$rose(wr_valid_q)))
    else $error("Pipeline moved while the output was stalled.");

endmodule

`default_nettype wire

// ===== verif/lcsd_level_checker.sv =====
`timescale 1ns / 100ps
// Checker for the LED channel scale and dither block: watches the channels,
// predicts each drive level and compares it with the block's result.
// Depends on lcsd_pkg.

module lcsd_level_checker
  import lcsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GainW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [ValueW-1:0]  channel_value_i,
  input  logic [SlotW-1:0]   slot_index_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [ValueW-1:0]  level_out_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [GainW-1:0]  gain_q;
  logic              dither_q;
  logic [ResW-1:0]   residual_q [SlotCount];
  logic [ValueW-1:0] expected_levels_q [$];

  // Scales one channel value and, when dithering applies, folds in and
  // updates the residual of its slot.
  function automatic logic [ValueW-1:0] predict_level(input logic [ValueW-1:0] value,
                                                      input logic [SlotW-1:0]  slot);
    logic [GainW-1:0]        g;
    logic [ValueW+GainW-1:0] product;
    logic [ExactW:0]         exact;
    logic [ExactW:0]         sum;
    logic [ExactW:0]         whole;
    logic [ValueW-1:0]       level;
    logic                    dithering;
    g = (gain_q > GainUnity) ? GainUnity : gain_q;
    product = value * g;
    exact = product[ValueW+GainW-1:8];
    dithering = dither_q && (int'(slot) < SlotCount);
    sum = dithering ? exact + residual_q[slot] : exact;
    whole = sum >> 8;
    level = (whole > LevelMax) ? LevelMax : whole[ValueW-1:0];
    if (dithering) begin
      residual_q[slot] = ResW'(sum - {level, 8'h00});
    end
    return level;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [ValueW-1:0] expected;
    if (!rst_ni) begin
      gain_q = GainUnity;
      dither_q = 1'b1;
      for (int i = 0; i < SlotCount; i++) begin
        residual_q[i] = ResW'(i * int'(DecorStep));
      end
      expected_levels_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_levels_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected item: expected none, actual level %0d",
                   $time, level_out_i);
        end else begin
          expected = expected_levels_q.pop_front();
          if (level_out_i !== expected) begin
            fail_count_o++;
            $display("%0t: level mismatch: expected %0d, actual %0d",
                     $time, expected, level_out_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_levels_q.push_back(predict_level(channel_value_i, slot_index_i));
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgGain) begin
          gain_q = cfg_wdata_i;
        end else if (cfg_idx_i == CfgDither) begin
          dither_q = cfg_wdata_i[0];
        end
      end
      pending_o = expected_levels_q.size();
    end
  end

endmodule

// ===== verif/tb_led_channel_scale_dither.sv =====
`timescale 1ns / 100ps
// Testbench top for the LED channel scale and dither block: drives items and
// register writes, and gives the verdict. Depends on lcsd_pkg,
// led_channel_scale_dither and lcsd_level_checker.

module tb_led_channel_scale_dither;
  import lcsd_pkg::*;

  localparam int StallLimit = 5000;
  localparam int SegItems   = 75;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgGain;
  logic [GainW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [ValueW-1:0]  channel_value_i = '0;
  logic [SlotW-1:0]   slot_index_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ValueW-1:0]  level_out_o;

  int fail_count;
  int pending_levels;
  int sender_idle_pct = 22;
  int recv_idle_pct = 68;
  int stall_cycles = 0;

  led_channel_scale_dither uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .channel_value_i, .slot_index_i,
    .out_valid_o, .out_ready_i, .level_out_o
  );

  lcsd_level_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .channel_value_i, .slot_index_i,
    .out_valid_i(out_valid_o), .out_ready_i, .level_out_i(level_out_o),
    .fail_count_o(fail_count), .pending_o(pending_levels)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_level(input logic [ValueW-1:0] value, input logic [SlotW-1:0] slot);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    channel_value_i <= value;
    slot_index_i <= slot;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_levels();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_levels != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [GainW-1:0] data);
    drain_levels();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [GainW-1:0]  gain;
    logic              dither;
    logic [ValueW-1:0] value;
    logic [SlotW-1:0]  slot;
    int                pick;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Unity gain with dithering: residual carries on repeated slots, edges of
    // the store and slots beyond it.
    write_reg(CfgGain, GainUnity);
    write_reg(CfgDither, GainW'(1'b1));
    send_level(8'd255, 10'd0);
    send_level(8'd255, 10'd0);
    send_level(8'd0, 10'd0);
    send_level(8'd128, 10'd767);
    send_level(8'd255, 10'd767);
    send_level(8'd1, 10'd768);
    send_level(8'd255, 10'd1023);
    send_level(8'd200, 10'd5);
    send_level(8'd200, 10'd5);
    send_level(8'd200, 10'd5);
    // Gain above unity is held at unity.
    write_reg(CfgGain, 17'h1FFFF);
    send_level(8'd255, 10'd1);
    send_level(8'd255, 10'd1023);
    send_level(8'd77, 10'd2);
    write_reg(CfgDither, GainW'(1'b0));
    send_level(8'd255, 10'd3);
    send_level(8'd100, 10'd3);
    write_reg(CfgGain, 17'd0);
    write_reg(CfgDither, GainW'(1'b1));
    send_level(8'd255, 10'd4);
    send_level(8'd0, 10'd4);

    for (int seg = 0; seg < 9; seg++) begin
      if (seg < 3) begin
        sender_idle_pct = 22;
        recv_idle_pct = 68;
      end else if (seg < 6) begin
        sender_idle_pct = 68;
        recv_idle_pct = 22;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: begin
          gain = GainUnity;
          dither = 1'b1;
        end
        1: begin
          gain = 17'h1FFFF;
          dither = 1'b0;
        end
        2: begin
          gain = 17'd0;
          dither = 1'b1;
        end
        default: begin
          gain = ($urandom_range(99) < 30) ? GainUnity - GainW'($urandom_range(255))
                                           : GainW'($urandom_range(17'h1FFFF));
          dither = ($urandom_range(99) < 70);
        end
      endcase
      write_reg(CfgGain, gain);
      write_reg(CfgDither, GainW'(dither));
      for (int n = 0; n < SegItems; n++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          slot = SlotW'($urandom_range(1023, SlotCount));
        end else if (pick < 35) begin
          slot = SlotW'($urandom_range(7));
        end else begin
          slot = SlotW'($urandom_range(SlotCount - 1));
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
          value = LevelMax;
        end else if (pick < 15) begin
          value = '0;
        end else begin
          value = ValueW'($urandom_range(255));
        end
        send_level(value, slot);
      end
    end

    drain_levels();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lcsd_pkg.sv
sv/led_channel_scale_dither.sv
verif/lcsd_level_checker.sv
verif/tb_led_channel_scale_dither.sv
